// File: rtl/hhlc_pkg.sv
// ----------------------------------------------------------------------------
// hhlc_pkg
// Shared constants, codes and types for the hysteresis heater level
// controller: fixed-point scaling, operand widths, action codes, status.
// ----------------------------------------------------------------------------
`default_nettype none

package hhlc_pkg;

   // fixed-point fraction bits of the drive level
   localparam int FRAC_BITS = 8;
   // 100 percent in level units
   localparam int FULL      = 100 << FRAC_BITS;

   localparam int TW   = 16;                   // temperature width
   localparam int LW   = 15;                   // drive level port width
   localparam int DW   = TW;                   // span / offset width (unsigned)
   localparam int QW   = $clog2(FULL + 1);     // quotient / level width
   localparam int NW   = DW + QW;              // dividend width
   localparam int CNTW = $clog2(QW + 1);

   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_MIN_TEMP  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_MAX_TEMP  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_IDLE_UNIT = 2'd2;

   localparam logic [2:0] ACT_HEAT_STOP  = 3'd0;
   localparam logic [2:0] ACT_HEAT_START = 3'd1;
   localparam logic [2:0] ACT_HEAT_LEVEL = 3'd2;
   localparam logic [2:0] ACT_IDLE_LEVEL = 3'd3;
   localparam logic [2:0] ACT_NONE       = 3'd4;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// File: rtl/hhlc_div.sv
// ----------------------------------------------------------------------------
// hhlc_div
// Serial restoring divider: one quotient bit per cycle through a single
// subtractor. The dividend's upper part must already be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module hhlc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [hhlc_pkg::NW-1:0]     numerator,
   input  wire logic [hhlc_pkg::DW-1:0]     divisor,
   output logic      [hhlc_pkg::QW-1:0]     quotient,
   output hhlc_pkg::div_status_type         status
);

   logic [hhlc_pkg::DW-1:0]   rem_ff,  rem_in;
   logic [hhlc_pkg::QW-1:0]   low_ff,  low_in;
   logic [hhlc_pkg::QW-1:0]   quo_ff,  quo_in;
   logic [hhlc_pkg::DW-1:0]   den_ff,  den_in;
   logic [hhlc_pkg::CNTW-1:0] cnt_ff,  cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [hhlc_pkg::DW:0]     trial;
   logic [hhlc_pkg::DW+1:0]   diff;

   assign trial = {rem_ff, low_ff[hhlc_pkg::QW-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numerator[hhlc_pkg::NW-1:hhlc_pkg::QW];
         low_in  = numerator[hhlc_pkg::QW-1:0];
         den_in  = divisor;
         quo_in  = '0;
         cnt_in  = hhlc_pkg::CNTW'(hhlc_pkg::QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low DW bits suffice
         if (!diff[hhlc_pkg::DW+1]) begin
            rem_in = diff[hhlc_pkg::DW-1:0];
            quo_in = {quo_ff[hhlc_pkg::QW-2:0], 1'b1};
         end else begin
            rem_in = trial[hhlc_pkg::DW-1:0];
            quo_in = {quo_ff[hhlc_pkg::QW-2:0], 1'b0};
         end
         low_in = {low_ff[hhlc_pkg::QW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hhlc_pkg::CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// File: rtl/hysteresis_heater_level_controller_unit.sv
// ----------------------------------------------------------------------------
// hysteresis_heater_level_controller_unit
// Hysteresis thermostat with a proportional drive level for the active unit.
// ----------------------------------------------------------------------------
// Each temperature sample is one transaction and yields one result. A threshold
// crossing passes through the decide and finish steps to rsp_valid, a clamped
// level also through the bound step, and a divided level also through the
// multiply and divide steps, where the serial restoring divider produces one
// quotient bit per cycle. req_ready returns in the same cycle as rsp_valid, as
// the sequencer goes back to idle when the result is loaded into the output register.
// req_ready is high only while the sequencer is idle; a finished result sits in
// the output register and the next sample may be taken while it waits.
// Thresholds and the idle-unit flag are written through the csr_ port; the user
// must do so only while no sample is in work, as the block does not enforce it.
`default_nettype none

module hysteresis_heater_level_controller_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [hhlc_pkg::TW-1:0]    req_temperature_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic             [2:0]                 rsp_action,
   output logic             [hhlc_pkg::LW-1:0]    rsp_drive_level,
   output logic                                   rsp_heating_now,
   input  wire logic                              csr_write_enable,
   input  wire logic        [hhlc_pkg::CSR_IW-1:0] csr_index,
   input  wire logic        [hhlc_pkg::TW-1:0]    csr_write_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_BOUND  = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   logic [2:0] state_ff, state_in;

   logic signed [hhlc_pkg::TW-1:0] min_ff, min_in;
   logic signed [hhlc_pkg::TW-1:0] max_ff, max_in;
   logic                           idle_ff, idle_in;
   logic                           heating_ff, heating_in;

   logic signed [hhlc_pkg::TW-1:0] sample_ff, sample_in;
   logic signed [hhlc_pkg::TW-1:0] low_ff, low_in;
   logic        [hhlc_pkg::DW-1:0] span_ff, span_in;
   logic        [hhlc_pkg::DW-1:0] offs_ff, offs_in;
   logic        [2:0]              action_ff, action_in;
   logic        [hhlc_pkg::QW-1:0] level_ff, level_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic        [2:0]              rsp_action_ff, rsp_action_in;
   logic        [hhlc_pkg::LW-1:0] rsp_level_ff, rsp_level_in;
   logic                           rsp_heat_ff, rsp_heat_in;

   logic signed [hhlc_pkg::TW:0]   mid_sum;
   logic signed [hhlc_pkg::TW:0]   span_s;
   logic signed [hhlc_pkg::TW:0]   offs_s;
   logic        [hhlc_pkg::NW-1:0] product;
   logic        [hhlc_pkg::QW-1:0] quotient;
   logic                           div_start;
   hhlc_pkg::div_status_type       div_status;

   assign mid_sum = {min_ff[hhlc_pkg::TW-1], min_ff} + {max_ff[hhlc_pkg::TW-1], max_ff};
   assign span_s  = {max_ff[hhlc_pkg::TW-1], max_ff} - {low_ff[hhlc_pkg::TW-1], low_ff};
   assign offs_s  = {sample_ff[hhlc_pkg::TW-1], sample_ff}
                  - {low_ff[hhlc_pkg::TW-1], low_ff};

   assign product   = hhlc_pkg::NW'(offs_ff) * hhlc_pkg::NW'(hhlc_pkg::FULL);
   assign div_start = (state_ff == S_MUL);

   hhlc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (product),
      .divisor   (span_ff),
      .quotient  (quotient),
      .status    (div_status)
   );

   always_comb begin
      state_in      = state_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      idle_in       = idle_ff;
      heating_in    = heating_ff;
      sample_in     = sample_ff;
      low_in        = low_ff;
      span_in       = span_ff;
      offs_in       = offs_ff;
      action_in     = action_ff;
      level_in      = level_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_action_in = rsp_action_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_heat_in   = rsp_heat_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            hhlc_pkg::CSR_MIN_TEMP:  min_in  = csr_write_data;
            hhlc_pkg::CSR_MAX_TEMP:  max_in  = csr_write_data;
            hhlc_pkg::CSR_IDLE_UNIT: idle_in = csr_write_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sample_in = req_temperature_sample;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            level_in = '0;
            state_in = S_FIN;
            priority if (heating_ff && sample_ff >= max_ff) begin
               heating_in = 1'b0;
               action_in  = hhlc_pkg::ACT_HEAT_STOP;
            end else if (!heating_ff && sample_ff <= min_ff) begin
               heating_in = 1'b1;
               action_in  = hhlc_pkg::ACT_HEAT_START;
            end else if (heating_ff) begin
               // floored midpoint: drop the LSB of the two's complement sum
               low_in    = idle_ff ? mid_sum[hhlc_pkg::TW:1] : min_ff;
               action_in = hhlc_pkg::ACT_HEAT_LEVEL;
               state_in  = S_BOUND;
            end else if (idle_ff) begin
               low_in    = min_ff;
               action_in = hhlc_pkg::ACT_IDLE_LEVEL;
               state_in  = S_BOUND;
            end else begin
               action_in = hhlc_pkg::ACT_NONE;
            end
         end
         S_BOUND: begin
            span_in = span_s[hhlc_pkg::DW-1:0];
            offs_in = offs_s[hhlc_pkg::DW-1:0];
            state_in = S_FIN;
            priority if (span_s <= 0) begin
               level_in = '0;
            end else if (offs_s <= 0) begin
               level_in = hhlc_pkg::QW'(hhlc_pkg::FULL);
            end else if (offs_s >= span_s) begin
               level_in = '0;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               level_in = hhlc_pkg::QW'(hhlc_pkg::FULL) - quotient;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = action_ff;
               rsp_level_in  = hhlc_pkg::LW'(level_ff);
               rsp_heat_in   = heating_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_ff       <= 16'sd320;
         max_ff       <= 16'sd352;
         idle_ff      <= 1'b1;
         heating_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         idle_ff      <= idle_in;
         heating_ff   <= heating_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      low_ff        <= low_in;
      span_ff       <= span_in;
      offs_ff       <= offs_in;
      action_ff     <= action_in;
      level_ff      <= level_in;
      rsp_action_ff <= rsp_action_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_heat_ff   <= rsp_heat_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_drive_level = rsp_level_ff;
   assign rsp_heating_now = rsp_heat_ff;

`ifndef SYNTHESIS
   a_level_only_for_level_actions: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == hhlc_pkg::ACT_HEAT_STOP ||
                    rsp_action == hhlc_pkg::ACT_HEAT_START ||
                    rsp_action == hhlc_pkg::ACT_NONE) |-> rsp_drive_level == '0)
      else $error("drive level nonzero for a non-level action");

   a_flag_matches_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == hhlc_pkg::ACT_HEAT_START |-> rsp_heating_now)
      else $error("heater start reported without heating flag");

   a_div_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide step");

   a_div_busy_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == S_DIV)
      else $error("divider running outside the divide step");

   a_accept_starts_decide: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DECIDE)
      else $error("accepted transaction did not enter decision step");
`endif

endmodule

`default_nettype wire

// File: tb/hysteresis_heater_level_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// hysteresis_heater_level_controller_unit_tb
// Self-checking bench for the hysteresis heater level controller. Each
// accepted temperature sample is run through a predictor that tracks the
// heating flag and thresholds. The action, drive level and flag it yields are
// queued and compared with every returned transaction. Directed corner
// samples come first, then random phases, each under a new threshold setting.
// ----------------------------------------------------------------------------

module hysteresis_heater_level_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 9;
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int STALL_LIMIT = 2000;   // cycles without any transaction
   localparam int DRAIN_CYCLES = 40;    // > longest level latency
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 50;

   localparam logic [hhlc_pkg::CSR_IW-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic signed [hhlc_pkg::TW-1:0] T_LOWEST = 16'sh8000;
   localparam logic signed [hhlc_pkg::TW-1:0] T_HIGHEST = 16'sh7FFF;

   typedef struct packed {
      logic [2:0] action;
      logic [hhlc_pkg::LW-1:0] level;
      logic heating;
   } heater_result_type;

   // tracks thresholds and heating flag, queues the predicted results
   class heater_scoreboard;
      int min_t;
      int max_t;
      bit idle_fitted;
      bit heating;
      heater_result_type due_q[$];
      int mismatches;
      int checked;
      int act_count[5];

      function new();
         min_t = 320;
         max_t = 352;
         idle_fitted = 1'b1;
         heating = 1'b0;
         mismatches = 0;
         checked = 0;
         foreach (act_count[i]) act_count[i] = 0;
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      function void write_reg(logic [hhlc_pkg::CSR_IW-1:0] idx,
                              logic [hhlc_pkg::TW-1:0] data);
         case (idx)
            hhlc_pkg::CSR_MIN_TEMP: min_t = int'($signed(data));
            hhlc_pkg::CSR_MAX_TEMP: max_t = int'($signed(data));
            hhlc_pkg::CSR_IDLE_UNIT: idle_fitted = data[0];
            default: ;
         endcase
      endfunction

      // 100 percent minus the clamped position of t between lo and hi
      function logic [hhlc_pkg::LW-1:0] drive_percent(int lo, int hi, int t);
         longint span;
         longint part;
         logic [31:0] lvl;
         if (hi <= lo) return '0;
         if (t <= lo) begin
            lvl = 32'(hhlc_pkg::FULL);
         end else if (t >= hi) begin
            lvl = '0;
         end else begin
            span = longint'(hi) - longint'(lo);
            part = ((longint'(t) - longint'(lo)) * hhlc_pkg::FULL) / span;
            lvl = 32'(hhlc_pkg::FULL - part);
         end
         return lvl[hhlc_pkg::LW-1:0];
      endfunction

      function void note_sample(logic signed [hhlc_pkg::TW-1:0] t_in);
         int t;
         int lo;
         heater_result_type r;
         t = int'(t_in);
         r.level = '0;
         if (heating && t >= max_t) begin
            heating = 1'b0;
            r.action = hhlc_pkg::ACT_HEAT_STOP;
         end else if (!heating && t <= min_t) begin
            heating = 1'b1;
            r.action = hhlc_pkg::ACT_HEAT_START;
         end else if (heating) begin
            // floored midpoint raises the heater's low bound
            lo = idle_fitted ? (min_t + max_t) >>> 1 : min_t;
            r.level = drive_percent(lo, max_t, t);
            r.action = hhlc_pkg::ACT_HEAT_LEVEL;
         end else if (idle_fitted) begin
            r.level = drive_percent(min_t, max_t, t);
            r.action = hhlc_pkg::ACT_IDLE_LEVEL;
         end else begin
            r.action = hhlc_pkg::ACT_NONE;
         end
         r.heating = heating;
         due_q.push_back(r);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         mismatches++;
         if (mismatches <= 20)
            $display("mismatch on %s at result %0d: got %0d, predicted %0d",
                     what, checked, got, want);
      endtask

      task check_result(logic [2:0] act, logic [hhlc_pkg::LW-1:0] lvl, logic heat);
         heater_result_type w;
         if (due_q.size() == 0) begin
            report_mismatch("unexpected transaction, action", act, -1);
            return;
         end
         w = due_q.pop_front();
         if (act !== w.action) report_mismatch("action", act, w.action);
         if (lvl !== w.level) report_mismatch("drive_level", lvl, w.level);
         if (heat !== w.heating) report_mismatch("heating_now", heat, w.heating);
         if (w.action <= hhlc_pkg::ACT_NONE) act_count[w.action]++;
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [hhlc_pkg::TW-1:0] req_temperature_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_action;
   logic [hhlc_pkg::LW-1:0] rsp_drive_level;
   logic rsp_heating_now;
   logic csr_write_enable = 1'b0;
   logic [hhlc_pkg::CSR_IW-1:0] csr_index = '0;
   logic [hhlc_pkg::TW-1:0] csr_write_data = '0;

   heater_scoreboard sb;
   int sent = 0;
   int settings = 0;
   int stall_cycles = 0;
   int hold_asks = 0;
   int hold_served = 0;
   bit sink_steady = 1'b0;

   hysteresis_heater_level_controller_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_temperature_sample(req_temperature_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_action(rsp_action),
      .rsp_drive_level(rsp_drive_level),
      .rsp_heating_now(rsp_heating_now),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic int clamp_temp(int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // samples cluster around the thresholds so the flag keeps toggling
   function automatic logic [hhlc_pkg::TW-1:0] pick_sample();
      int lo;
      int hi;
      int w;
      int r;
      lo = sb.min_t < sb.max_t ? sb.min_t : sb.max_t;
      hi = sb.min_t < sb.max_t ? sb.max_t : sb.min_t;
      w = (hi - lo) / 4 + 2;
      r = $urandom_range(0, 99);
      if (r < 70)
         return hhlc_pkg::TW'(clamp_temp(lo - w + int'($urandom_range(0, hi - lo + 2 * w))));
      if (r < 80)
         return hhlc_pkg::TW'(clamp_temp((r[0] ? sb.min_t : sb.max_t)
                                         + int'($urandom_range(0, 4)) - 2));
      if (r < 85)
         return hhlc_pkg::TW'(clamp_temp(((sb.min_t + sb.max_t) >>> 1)
                                         + int'($urandom_range(0, 4)) - 2));
      return hhlc_pkg::TW'($urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_action, rsp_drive_level, rsp_heating_now);
         if (req_valid && req_ready)
            sb.note_sample(req_temperature_sample);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("hysteresis_heater_level_controller_unit_tb failed");
         $finish;
      end
   end

   // result sink: random ready, plus one long hold-off per request
   always begin : rsp_sink
      int gap;
      if (hold_asks != hold_served) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_served++;
      end else begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = sink_steady ? 0 : idle_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic offer_sample(input logic signed [hhlc_pkg::TW-1:0] t);
      req_valid <= 1'b1;
      req_temperature_sample <= t;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // first edge lets the monitor log the last transaction
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [hhlc_pkg::CSR_IW-1:0] idx,
                            input logic [hhlc_pkg::TW-1:0] data);
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_setting(input int lo, input int hi, input bit idle, input bit poke);
      logic [hhlc_pkg::TW-1:0] flag_word;
      flag_word = hhlc_pkg::TW'($urandom);
      if ($urandom_range(0, 1)) flag_word[hhlc_pkg::TW-1:1] = '0;
      flag_word[0] = idle;
      csr_write_enable <= 1'b1;
      csr_write(hhlc_pkg::CSR_MIN_TEMP, hhlc_pkg::TW'(lo));
      csr_write(hhlc_pkg::CSR_MAX_TEMP, hhlc_pkg::TW'(hi));
      csr_write(hhlc_pkg::CSR_IDLE_UNIT, flag_word);
      if (poke) csr_write(CSR_UNMAPPED, hhlc_pkg::TW'($urandom));
      csr_write_enable <= 1'b0;
      settings++;
   endtask

   task automatic random_setting(input int mode);
      int lo;
      int hi;
      case (mode)
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: begin
            // inverted thresholds
            lo = int'($signed(hhlc_pkg::TW'($urandom)));
            hi = clamp_temp(lo - int'($urandom_range(1, 500)));
         end
         2: begin
            lo = int'($signed(hhlc_pkg::TW'($urandom)));
            hi = lo;
         end
         3: begin
            if ($urandom_range(0, 1)) begin
               lo = 32766;
               hi = 32767;
            end else begin
               lo = -32768;
               hi = -32767 + int'($urandom_range(0, 3));
            end
         end
         default: begin
            lo = int'($signed(hhlc_pkg::TW'($urandom)));
            hi = clamp_temp(lo + int'($urandom_range(1, 3000)));
         end
      endcase
      apply_setting(lo, hi, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
   endtask

   task automatic random_phase(input int n_items, input bit squeeze, input bit midway_drain);
      bit steady;
      steady = ($urandom_range(0, 3) == 0);
      sink_steady = steady;
      for (int i = 0; i < n_items; i++) begin
         if (squeeze && i == 8) hold_asks++;
         if (midway_drain && i == n_items / 2) drain();
         offer_sample(pick_sample());
         // back-to-back in steady phases, and while the sink holds off so the block backs up
         if (!steady && !(squeeze && i >= 8 && i < 24)) pause_sender(idle_gap());
      end
      drain();
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: idle levels, both crossings, heater levels
      offer_sample(16'sd400);
      offer_sample(16'sd336);
      offer_sample(T_HIGHEST);
      offer_sample(16'sd321);
      offer_sample(16'sd320);
      offer_sample(T_LOWEST);
      offer_sample(16'sd340);
      offer_sample(16'sd351);
      offer_sample(16'sd352);
      offer_sample(T_LOWEST);
      offer_sample(T_HIGHEST);
      drain();

      // no idle unit: nothing to drive while off, heater low bound is min
      apply_setting(320, 352, 1'b0, 1'b1);
      offer_sample(16'sd330);
      offer_sample(16'sd300);
      offer_sample(16'sd330);
      offer_sample(16'sd352);
      drain();

      // widest span
      apply_setting(-32768, 32767, 1'b1, 1'b0);
      offer_sample(T_LOWEST);
      offer_sample(16'sd0);
      offer_sample(16'sh7FFE);
      offer_sample(T_HIGHEST);
      offer_sample(16'sh8001);
      drain();

      // inverted thresholds, then equal ones
      apply_setting(100, -100, 1'b1, 1'b0);
      offer_sample(16'sd0);
      offer_sample(16'sd0);
      offer_sample(16'sd200);
      drain();
      apply_setting(50, 50, 1'b0, 1'b0);
      offer_sample(16'sd60);
      offer_sample(16'sd50);
      offer_sample(16'sd49);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         random_setting(p == 0 ? 0 : int'($urandom_range(0, 9)));
         random_phase(PHASE_ITEMS, p == 2, p == 4);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d samples sent, %0d results checked under %0d threshold settings",
               sent, sb.checked, settings);
      $display("actions: stop %0d, start %0d, heat level %0d, idle level %0d, none %0d",
               sb.act_count[hhlc_pkg::ACT_HEAT_STOP], sb.act_count[hhlc_pkg::ACT_HEAT_START],
               sb.act_count[hhlc_pkg::ACT_HEAT_LEVEL], sb.act_count[hhlc_pkg::ACT_IDLE_LEVEL],
               sb.act_count[hhlc_pkg::ACT_NONE]);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("hysteresis_heater_level_controller_unit_tb passed");
      else
         $display("hysteresis_heater_level_controller_unit_tb failed");
      $finish;
   end

endmodule

// File: hysteresis_heater_level_controller_unit.f
rtl/hhlc_pkg.sv
rtl/hhlc_div.sv
rtl/hysteresis_heater_level_controller_unit.sv
tb/hysteresis_heater_level_controller_unit_tb.sv
